>>> rtl/ppr_pkg.sv
// Shared types, constants and helpers for the packet period recovery tick.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ppr_pkg;

  localparam int unsigned EMA_SHIFT         = 6;
  localparam int unsigned PHASE_DIVISOR     = 4;
  localparam int unsigned INITIAL_PERIOD_US = 1000;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned ACC_W  = 32;
  localparam int unsigned PER_W  = 26;
  localparam int unsigned GAP_W  = 16;
  localparam int unsigned DIVR_W = GAP_W - 1;   // positive gaps only
  localparam int unsigned CNT_W  = $clog2(ACC_W);

  localparam logic [ACC_W-1:0] ACC_INIT   = ACC_W'(INITIAL_PERIOD_US << EMA_SHIFT);
  localparam logic [PER_W-1:0] PERIOD_MAX = {PER_W{1'b1}};

  typedef enum logic {
    REQ_PACKET = 1'b0,
    REQ_TIME   = 1'b1
  } req_type_t;

  // Controller to datapath
  typedef struct packed {
    logic load;       // latch an accepted word, preload the divider
    logic div_step;   // one restoring divide step
    logic ema_upd;    // fold the quotient into the average
    logic commit;     // update state, load the result register
  } ppr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_need;   // packet with a prior arrival and a positive gap
    logic div_last;   // final divide step is in progress
  } ppr_sts_t;

  // Integer period from the scaled accumulator, kept in 1..PERIOD_MAX.
  function automatic logic [PER_W-1:0] cur_period(input logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] sh;
    sh = acc >> EMA_SHIFT;
    if (sh == '0) begin
      cur_period = PER_W'(1);
    end else if (sh > ACC_W'(PERIOD_MAX)) begin
      cur_period = PERIOD_MAX;
    end else begin
      cur_period = sh[PER_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/ppr_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on ppr_pkg for field widths.
`default_nettype none

interface ppr_in_if;
  import ppr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [TIME_W-1:0]        now_us;
  logic signed [GAP_W-1:0]  id_gap;

  modport source (output valid, output req_type, output now_us, output id_gap,
                  input ready);
  modport sink   (input valid, input req_type, input now_us, input id_gap,
                  output ready);
endinterface

interface ppr_out_if;
  import ppr_pkg::*;
  logic              valid;
  logic              ready;
  logic              tick_fire;
  logic [PER_W-1:0]  avg_period;
  logic              period_changed;
  logic [TIME_W-1:0] next_fire_us;

  modport source (output valid, output tick_fire, output avg_period,
                  output period_changed, output next_fire_us, input ready);
  modport sink   (input valid, input tick_fire, input avg_period,
                  input period_changed, input next_fire_us, output ready);
endinterface

`default_nettype wire

>>> rtl/ppr_ctrl.sv
// Sequencing state machine for the packet period recovery tick.
// Depends on ppr_pkg for the command and status structs.
`default_nettype none

module ppr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  ppr_pkg::ppr_sts_t sts,
  output ppr_pkg::ppr_cmd_t cmd
);
  import ppr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_DIV  = 5'b00100,
    S_UPD  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.div_step = (state_r == S_DIV);
    cmd.ema_upd  = (state_r == S_UPD);
    cmd.commit   = (state_r == S_FIN) && out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_CHK;
      S_CHK:  state_nxt = sts.div_need ? S_DIV : S_FIN;
      S_DIV:  if (sts.div_last) state_nxt = S_UPD;
      S_UPD:  state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ppr_dp.sv
// Datapath: tracking state, serial interval divider, average and tick timing.
// Depends on ppr_pkg; steered by ppr_ctrl through ppr_cmd_t.
`default_nettype none

module ppr_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ppr_pkg::ppr_cmd_t           cmd,
  output ppr_pkg::ppr_sts_t           sts,
  input  logic                        in_req_type,
  input  logic [ppr_pkg::TIME_W-1:0]  in_now_us,
  input  logic [ppr_pkg::GAP_W-1:0]   in_id_gap,
  output logic                        out_tick_fire,
  output logic [ppr_pkg::PER_W-1:0]   out_avg_period,
  output logic                        out_period_changed,
  output logic [ppr_pkg::TIME_W-1:0]  out_next_fire_us
);
  import ppr_pkg::*;

  // Tracking state
  logic [ACC_W-1:0]  ema_r, ema_nxt;
  logic [PER_W-1:0]  rep_r, rep_nxt;
  logic [TIME_W-1:0] last_r, last_nxt;
  logic              seen_r, seen_nxt;
  logic [TIME_W-1:0] fire_r, fire_nxt;
  logic              armed_r, armed_nxt;

  // Latched request word
  logic              typ_r;
  logic [TIME_W-1:0] now_r;
  logic [DIVR_W-1:0] gap_r;
  logic              gap_ok_r;

  // Divider
  logic [ACC_W-1:0]  quo_r;
  logic [DIVR_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVR_W:0]   rem_sh;
  logic [DIVR_W:0]   rem_diff;
  logic              qbit;

  // Result register
  logic              res_fire_r;
  logic [PER_W-1:0]  res_per_r;
  logic              res_chg_r;
  logic [TIME_W-1:0] res_next_r;

  logic [PER_W-1:0]  period;
  logic [TIME_W-1:0] phase_off;
  logic              fire;
  logic              changed;

  assign sts.div_need = (typ_r == REQ_PACKET) && seen_r && gap_ok_r;
  assign sts.div_last = (cnt_r == {CNT_W{1'b1}});

  // Restoring divide step: shift in the next dividend bit, try the subtract
  assign rem_sh   = {rem_r, quo_r[ACC_W-1]};
  assign rem_diff = rem_sh - {1'b0, gap_r};
  assign qbit     = (rem_sh >= {1'b0, gap_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      typ_r    <= in_req_type;
      now_r    <= in_now_us;
      gap_r    <= in_id_gap[DIVR_W-1:0];
      gap_ok_r <= !in_id_gap[GAP_W-1] && (in_id_gap != '0);
      // interval modulo 2^32
      quo_r    <= in_now_us[ACC_W-1:0] - last_r[ACC_W-1:0];
      rem_r    <= '0;
      cnt_r    <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[ACC_W-2:0], qbit};
      rem_r <= qbit ? rem_diff[DIVR_W-1:0] : rem_sh[DIVR_W-1:0];
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  assign period    = cur_period(ema_r);
  assign phase_off = {{(TIME_W-PER_W){1'b0}}, period / PER_W'(PHASE_DIVISOR)};

  always_comb begin
    ema_nxt   = ema_r;
    rep_nxt   = rep_r;
    last_nxt  = last_r;
    seen_nxt  = seen_r;
    fire_nxt  = fire_r;
    armed_nxt = armed_r;
    fire      = 1'b0;
    changed   = 1'b0;
    if (cmd.ema_upd) begin
      ema_nxt = ema_r - (ema_r >> EMA_SHIFT) + quo_r;
    end
    if (cmd.commit) begin
      if (typ_r == REQ_PACKET) begin
        last_nxt  = now_r;
        seen_nxt  = 1'b1;
        changed   = (rep_r != period);
        rep_nxt   = period;
        fire_nxt  = now_r + phase_off;
        armed_nxt = 1'b1;
      end else if (!armed_r) begin
        rep_nxt   = period;
        fire_nxt  = now_r + phase_off;
        armed_nxt = 1'b1;
      end else if (now_r >= fire_r) begin
        fire     = 1'b1;
        fire_nxt = fire_r + {{(TIME_W-PER_W){1'b0}}, period};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ema_r   <= ACC_INIT;
      rep_r   <= '0;
      last_r  <= '0;
      seen_r  <= 1'b0;
      fire_r  <= '0;
      armed_r <= 1'b0;
    end else begin
      ema_r   <= ema_nxt;
      rep_r   <= rep_nxt;
      last_r  <= last_nxt;
      seen_r  <= seen_nxt;
      fire_r  <= fire_nxt;
      armed_r <= armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_fire_r <= fire;
      res_per_r  <= period;
      res_chg_r  <= changed;
      res_next_r <= fire_nxt;
    end
  end

  assign out_tick_fire      = res_fire_r;
  assign out_avg_period     = res_per_r;
  assign out_period_changed = res_chg_r;
  assign out_next_fire_us   = res_next_r;

endmodule

`default_nettype wire

>>> rtl/packet_period_recovery_tick.sv
// Top level of the packet period recovery tick.
// Depends on ppr_pkg, ppr_if (channel interfaces), ppr_ctrl and ppr_dp.
`default_nettype none

// Recovers a tick period from packet arrivals and keeps a tick phase-locked
// to them. Each request word is either a packet arrival (arrival time and id
// gap) or a time update, and each gives exactly one result word. A packet
// that follows an earlier packet with a positive id gap folds interval/gap
// into a moving average (alpha 1/64, 32-bit accumulator scaled by 64, wraps);
// the reported period is the average rounded down, at least 1. Every packet
// re-arms the tick at arrival plus a quarter period; a time update fires the
// tick once the armed time is reached and moves it on by one period; if no
// tick is armed yet, it arms one at the update time plus a quarter period. A
// packet that updates the average passes the check, the 32-step restoring
// divider (one quotient bit per cycle), average update and finish steps;
// other words pass only the check and finish steps. The result sits in an
// output register, so the next word is accepted while an earlier result still
// waits to be taken; the finish step holds only if that register is occupied.
module packet_period_recovery_tick (
  input  logic  clk,
  input  logic  rst_n,
  ppr_in_if.sink     in_ch,
  ppr_out_if.source  out_ch
);
  import ppr_pkg::*;

  ppr_cmd_t cmd;
  ppr_sts_t sts;

  // Sequencer: accept, check, divide, update average, finish
  ppr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // State, divider, timing arithmetic and result register
  ppr_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_req_type        (in_ch.req_type),
    .in_now_us          (in_ch.now_us),
    .in_id_gap          (in_ch.id_gap),
    .out_tick_fire      (out_ch.tick_fire),
    .out_avg_period     (out_ch.avg_period),
    .out_period_changed (out_ch.period_changed),
    .out_next_fire_us   (out_ch.next_fire_us)
  );

endmodule

`default_nettype wire
